// ===== hdl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// No dependencies; imported by fpba_engine and fit_policy_block_allocator.
`timescale 1ns / 1ps

package fpba_pkg;

   localparam int MAX_BLOCKS    = 16;
   localparam int SIZE_BITS     = 32;
   localparam int IDX_BITS      = $clog2(MAX_BLOCKS);
   localparam int SCAN_BITS     = $clog2(MAX_BLOCKS + 1);

   localparam int SLOT_BITS     = 4;
   localparam int AMOUNT_BITS   = 32;
   localparam int COUNT_BITS    = 5;
   localparam int CSR_DATA_BITS = 5;

   localparam int REQ_DATA_BITS = ((SLOT_BITS + AMOUNT_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((1 + SLOT_BITS + 7) / 8) * 8;

   typedef enum logic [0:0] {
      CSR_STRATEGY      = 1'b0,
      CSR_BLOCKS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_ALLOC = 1'b1
   } action_type;

   typedef enum logic {
      FIT_FIRST = 1'b0,
      FIT_BEST  = 1'b1
   } fit_type;

   typedef struct packed {
      action_type             action;
      logic [SLOT_BITS-1:0]   slot;
      logic [AMOUNT_BITS-1:0] amount;
   } cmd_type;

   typedef struct packed {
      logic                 granted;
      logic [SLOT_BITS-1:0] chosen_block;
   } res_type;

   // top -> engine
   typedef struct packed {
      logic                 start;
      logic                 res_take;
      fit_type              strategy;
      logic [SCAN_BITS-1:0] scan_len;
   } eng_ctl_type;

   // engine -> top
   typedef struct packed {
      logic    idle;
      logic    res_valid;
      res_type res;
   } eng_stat_type;

endpackage

// ===== hdl/fpba_engine.sv =====
// Free-space table and scan engine of the allocator.
// Depends on fpba_pkg; instantiated by fit_policy_block_allocator.
`timescale 1ns / 1ps

module fpba_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  fpba_pkg::eng_ctl_type  ctl,
   input  fpba_pkg::cmd_type      cmd,
   output fpba_pkg::eng_stat_type stat
);
   import fpba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SCAN_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic [SIZE_BITS-1:0] amount_ff, amount_in;

   logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic [IDX_BITS-1:0]  rd_idx;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;

   logic                 issue;
   logic                 take;
   logic [SIZE_BITS-1:0] cmd_size;

   assign rd_idx   = rd_ptr_ff[IDX_BITS-1:0];
   assign cmd_size = SIZE_BITS'(cmd.amount);
   assign issue    = (state_ff == ST_SCAN) && (rd_ptr_ff != ctl.scan_len);
   // entry fits, and is the first fit or strictly smaller than the best so far
   assign take     = rd_valid_ff && (rd_data_ff >= amount_ff) &&
                     (!found_ff || (ctl.strategy == FIT_BEST && rd_data_ff < best_ff));

   always_comb begin
      state_in    = state_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_valid_in = 1'b0;
      cmp_idx_in  = rd_idx;
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      amount_in   = amount_ff;
      mem_we      = 1'b0;
      mem_waddr   = IDX_BITS'(cmd.slot);
      mem_wdata   = cmd_size;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               if (cmd.action == ACT_LOAD) begin
                  mem_we = (32'(cmd.slot) < MAX_BLOCKS);
               end else begin
                  rd_ptr_in = '0;
                  found_in  = 1'b0;
                  pick_in   = '0;
                  amount_in = cmd_size;
                  state_in  = (ctl.scan_len == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_valid_in = issue;
            rd_ptr_in   = rd_ptr_ff + SCAN_BITS'(issue);
            if (take) begin
               found_in = 1'b1;
               pick_in  = cmp_idx_ff;
               best_in  = rd_data_ff;
            end
            if ((take && ctl.strategy == FIT_FIRST) || !issue) begin
               state_in    = ST_FINISH;
               rd_valid_in = 1'b0;
            end
         end
         ST_FINISH: begin
            if (ctl.res_take) begin
               mem_we    = found_ff;
               mem_waddr = pick_ff;
               mem_wdata = best_ff - amount_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
      amount_ff  <= amount_in;
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign stat.idle             = (state_ff == ST_IDLE);
   assign stat.res_valid        = (state_ff == ST_FINISH);
   assign stat.res.granted      = found_ff;
   assign stat.res.chosen_block = found_ff ? SLOT_BITS'(pick_ff) : '0;

endmodule

// ===== hdl/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator: stream ports, config registers, result register.
// Depends on fpba_pkg and fpba_engine.
`timescale 1ns / 1ps

// Channel   Direction  Contents
// req_*     in         tuser: action; tdata: block_slot [3:0], amount [35:4], zero pad
// rsp_*     out        tdata: granted [0], chosen_block [4:1], zero pad
// csr_*     in         csr_index 0 = strategy, 1 = blocks_in_use; write on csr_we
//
// A load writes one table entry and leaves the engine idle. An allocate request scans the first n
// entries, n being blocks_in_use capped at 16: the free-space table has one
// registered read port and is scanned one entry a cycle. First fit stops at
// the first hit. Synchronous active-high reset clears control state; the
// table is undefined until loaded. A stalled result sits in the output
// register while the next request is taken; the engine then holds its own
// result until that register frees up.

module fit_policy_block_allocator (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fpba_pkg::REQ_DATA_BITS-1:0] req_tdata,  // block_slot, amount, pad
   input  logic [0:0]                         req_tuser,  // action
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fpba_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // granted, chosen_block, pad
   // config port
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [fpba_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import fpba_pkg::*;

   fit_type               strategy_ff;
   logic [COUNT_BITS-1:0] blocks_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   res_type               rsp_res_ff;

   eng_ctl_type           ctl;
   eng_stat_type          stat;
   cmd_type               cmd;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= FIT_FIRST;
         blocks_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STRATEGY:      strategy_ff <= fit_type'(csr_wdata[0]);
            CSR_BLOCKS_IN_USE: blocks_ff   <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request unpack
   assign cmd.action = action_type'(req_tuser[0]);
   assign cmd.slot   = req_tdata[SLOT_BITS-1:0];
   assign cmd.amount = req_tdata[SLOT_BITS +: AMOUNT_BITS];

   assign req_tready = stat.idle;

   // scan length saturates at the table depth
   assign ctl.start    = req_tvalid && req_tready;
   assign ctl.strategy = strategy_ff;
   assign ctl.scan_len = (32'(blocks_ff) > MAX_BLOCKS) ? SCAN_BITS'(MAX_BLOCKS)
                                                       : SCAN_BITS'(blocks_ff);
   assign ctl.res_take = stat.res_valid && (!rsp_valid_ff || rsp_tready);

   fpba_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .cmd   (cmd),
      .stat  (stat)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.res_take) begin
         rsp_res_ff <= stat.res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_res_ff.chosen_block, rsp_res_ff.granted});

   // an allocate request keeps the engine busy: req_tready drops once it is taken
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == ACT_ALLOC) |=> !req_tready)
      else $error("engine took a request while a scan was pending");

   // a load never blocks the next request
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == ACT_LOAD) |=> req_tready)
      else $error("load did not finish in one cycle");

   // a result handed to the output register comes with new valid data next cycle
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      ctl.res_take |=> rsp_tvalid && rsp_tdata == RSP_DATA_BITS'($past(
         {stat.res.chosen_block, stat.res.granted})))
      else $error("result lost between engine and output register");

   // refused requests report block zero
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (stat.res_valid && !stat.res.granted) |-> stat.res.chosen_block == '0)
      else $error("refused request carries a block index");

endmodule
